### src/ces_pkg.sv
// Package for the CAN signal extract and scale block.
// Beat types, configuration register indexes and error codes.
// No dependencies.
package ces_pkg;

  localparam int MaxPayloadBytesDef = 8;
  localparam int CfgIdxW            = 3;
  localparam int CfgDataW           = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_ID   = 3'd0,
    REG_START_BIT  = 3'd1,
    REG_LENGTH     = 3'd2,
    REG_BIG_ENDIAN = 3'd3,
    REG_OFFSET     = 3'd4,
    REG_MULTIPLIER = 3'd5,
    REG_DIVIDER    = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_ID        = 3'd1,
    ERR_DLC       = 3'd2,
    ERR_FIELD     = 3'd3,
    ERR_ZERO_DIV  = 3'd4
  } err_code_t;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [63:0] payload;
    logic [3:0]  byte_count;
  } in_beat_t;

  typedef struct packed {
    logic [63:0]        raw_value;
    logic signed [63:0] scaled_value;
    logic [2:0]         error_code;
  } out_beat_t;

endpackage

### src/can_signal_extract_scale.sv
// Top level of the CAN signal extract and scale block.
// Uses ces_pkg for beat types, register indexes and error codes.
//
// Usage:
//  - Input: a frame beat on in_data is taken at a rising edge with start high
//    and busy low. busy is always low: a new frame may be offered every cycle.
//  - Output: out_valid strobes for one cycle with out_data once the frame has
//    passed every stage. Results leave in order, one per frame.
//  - Configuration: cfg_we, cfg_index, cfg_wdata write one register per edge;
//    write only while no frame is in flight.
//  - Throughput: one frame per cycle. The latency comes from seven front
//    stages (capture at the accepting edge, checks and masking, field
//    extraction, offset add, partial products, product sum, sign split)
//    followed by a 64-stage restoring divider, one quotient bit per stage,
//    and an output register.
//  - Reset: rst_n low clears all valid bits and restores register defaults;
//    frames in flight are dropped.
//  - The receiver cannot stall; out_valid is a plain strobe.
//  - On any error raw_value and scaled_value are zero.
module can_signal_extract_scale
  import ces_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MaxPayloadBytesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_beat_t            in_data,
  output logic                out_valid,
  output out_beat_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int DivSteps = 64;
  localparam logic [3:0] MaxDlc = 4'(MAX_PAYLOAD_BYTES);
  localparam logic [3:0] HardDlc = 4'd8;

  // configuration
  logic [28:0]        exp_id_r;
  logic [5:0]         start_bit_r;
  logic [6:0]         length_r;
  logic               big_endian_r;
  logic signed [31:0] offset_r;
  logic signed [31:0] mult_r;
  logic signed [31:0] div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r     <= '0;
      start_bit_r  <= '0;
      length_r     <= 7'd8;
      big_endian_r <= 1'b0;
      offset_r     <= '0;
      mult_r       <= 32'sd1;
      div_r        <= 32'sd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_FRAME_ID:   exp_id_r     <= cfg_wdata[28:0];
        REG_START_BIT:  start_bit_r  <= cfg_wdata[5:0];
        REG_LENGTH:     length_r     <= cfg_wdata[6:0];
        REG_BIG_ENDIAN: big_endian_r <= cfg_wdata[0];
        REG_OFFSET:     offset_r     <= cfg_wdata;
        REG_MULTIPLIER: mult_r       <= cfg_wdata;
        REG_DIVIDER:    div_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: capture
  logic     v0_r;
  in_beat_t in0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy;
  end
  always_ff @(posedge clk) in0_r <= in_data;

  // stage 1: checks, byte mask, align field to the top
  logic        v1_r;
  err_code_t   err1_r, err1_nxt;
  logic [63:0] q1_r, q1_nxt;
  logic [7:0]  fend;
  logic [63:0] pmask;

  always_comb begin
    fend = {2'b00, start_bit_r} + {1'b0, length_r};
    for (int b = 0; b < 8; b++) begin
      pmask[63-8*b -: 8] = (4'(b) < in0_r.byte_count) ? 8'hFF : 8'h00;
    end
    q1_nxt = (in0_r.payload & pmask) << start_bit_r;
    if (in0_r.byte_count > MaxDlc || in0_r.byte_count > HardDlc)
      err1_nxt = ERR_DLC;
    else if (in0_r.frame_id != exp_id_r)
      err1_nxt = ERR_ID;
    else if (fend > {1'b0, in0_r.byte_count, 3'b000})
      err1_nxt = ERR_FIELD;
    else if (div_r == 32'sd0)
      err1_nxt = ERR_ZERO_DIV;
    else
      err1_nxt = ERR_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
  end
  always_ff @(posedge clk) begin
    err1_r <= err1_nxt;
    q1_r   <= q1_nxt;
  end

  // stage 2: field extraction
  logic        v2_r;
  err_code_t   err2_r;
  logic [63:0] raw2_r, raw2_nxt;
  logic [3:0]  nfull;
  logic [2:0]  nrem;
  logic [7:0]  qbyte;

  always_comb begin
    nfull    = length_r[6:3];
    nrem     = length_r[2:0];
    raw2_nxt = '0;
    qbyte    = '0;
    if (err1_r != ERR_OK) begin
      raw2_nxt = '0;
    end else if (big_endian_r) begin
      raw2_nxt = (length_r == 7'd0) ? 64'd0 : (q1_r >> (7'd64 - length_r));
    end else begin
      for (int g = 0; g < 8; g++) begin
        qbyte = q1_r[63-8*g -: 8];
        if (4'(g) < nfull)
          raw2_nxt[8*g +: 8] = qbyte;
        else if (4'(g) == nfull && nrem != 3'd0)
          raw2_nxt[8*g +: 8] = qbyte >> (4'd8 - {1'b0, nrem});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    err2_r <= err1_r;
    raw2_r <= raw2_nxt;
  end

  // stage 3: add offset
  logic        v3_r;
  err_code_t   err3_r;
  logic [63:0] raw3_r, sum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    err3_r <= err2_r;
    raw3_r <= raw2_r;
    sum3_r <= raw2_r + {{32{offset_r[31]}}, offset_r};
  end

  // stage 4: partial products, product kept modulo 2^64
  logic        v4_r;
  err_code_t   err4_r;
  logic [63:0] raw4_r, pp0_r, pp1_r, pp2_r;
  logic [31:0] m_hi;

  assign m_hi = {32{mult_r[31]}};

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    err4_r <= err3_r;
    raw4_r <= raw3_r;
    pp0_r  <= sum3_r[31:0]  * mult_r[31:0];
    pp1_r  <= sum3_r[63:32] * mult_r[31:0];
    pp2_r  <= sum3_r[31:0]  * m_hi;
  end

  // stage 5: product sum
  logic        v5_r;
  err_code_t   err5_r;
  logic [63:0] raw5_r, prod5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    err5_r  <= err4_r;
    raw5_r  <= raw4_r;
    prod5_r <= pp0_r + {pp1_r[31:0] + pp2_r[31:0], 32'd0};
  end

  // stage 6: magnitude and result sign; feeds divider step zero
  logic        dv_r   [0:DivSteps];
  err_code_t   derr_r [0:DivSteps];
  logic [63:0] draw_r [0:DivSteps];
  logic        dneg_r [0:DivSteps];
  logic [31:0] drem_r [0:DivSteps];
  logic [63:0] dwq_r  [0:DivSteps];
  logic [31:0] ud;

  assign ud = div_r[31] ? 32'(-div_r) : div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= v5_r;
  end
  always_ff @(posedge clk) begin
    derr_r[0] <= err5_r;
    draw_r[0] <= raw5_r;
    dneg_r[0] <= prod5_r[63] ^ div_r[31];
    drem_r[0] <= '0;
    dwq_r[0]  <= prod5_r[63] ? (64'd0 - prod5_r) : prod5_r;
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    logic [32:0] trial;
    logic        ge;

    assign trial = {drem_r[k-1], dwq_r[k-1][63]};
    assign ge    = trial >= {1'b0, ud};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k] <= 1'b0;
      else        dv_r[k] <= dv_r[k-1];
    end
    always_ff @(posedge clk) begin
      derr_r[k] <= derr_r[k-1];
      draw_r[k] <= draw_r[k-1];
      dneg_r[k] <= dneg_r[k-1];
      drem_r[k] <= ge ? 32'(trial - {1'b0, ud}) : trial[31:0];
      dwq_r[k]  <= {dwq_r[k-1][62:0], ge};
    end
  end

  // output register
  logic [63:0] quo;

  assign quo = dwq_r[DivSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= dv_r[DivSteps];
  end
  always_ff @(posedge clk) begin
    out_data.error_code   <= derr_r[DivSteps];
    out_data.raw_value    <= draw_r[DivSteps];
    if (derr_r[DivSteps] != ERR_OK)
      out_data.scaled_value <= '0;
    else
      out_data.scaled_value <= dneg_r[DivSteps] ? (64'd0 - quo) : quo;
  end

`ifndef SYNTHESIS
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error_code <= ERR_ZERO_DIV))
    else $error("error code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != ERR_OK) |->
      (out_data.raw_value == 64'd0 && out_data.scaled_value == 64'sd0))
    else $error("non-zero result on error beat");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat straight after reset");

  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[0] |=> dv_r[1])
    else $error("beat lost entering divider");
`endif

endmodule
